// File: src/lz77_pkg.sv
// lz77 token encoder: shared types and constants
// used by the input queue, the match engine and the top level
`default_nettype none

package lz77_pkg;

  localparam int OFFSET_W  = 16;
  localparam int LENGTH_W  = 5;
  localparam int BYTE_W    = 8;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic              eos;
    logic [BYTE_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [BYTE_W-1:0]   literal;
    logic                last;
  } token_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CONSUME,
    ST_EMIT
  } eng_state_t;

endpackage

`default_nettype wire

// File: src/lz77_in_queue.sv
// lz77 input side: accepts byte requests and queues them for the engine
// depends on lz77_pkg
`default_nettype none

module lz77_in_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,  // data_byte
  input  wire logic               s_tlast,  // end_of_stream
  output logic                    q_valid,
  output lz77_pkg::in_item_t      q_item,
  input  wire logic               q_pop
);

  localparam int DEPTH = 4;
  localparam int PW    = 2;

  lz77_pkg::in_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;
  logic          push;
  logic          pop;

  assign s_tready = (fill != (PW+1)'(DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr].data <= s_tdata;
      mem[wr_ptr].eos  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: src/lz77_match_engine.sv
// lz77 back end: lookahead lanes, history memory, match scan and token register
// depends on lz77_pkg
`default_nettype none

module lz77_match_engine #(
  parameter int WINDOW_SIZE    = 32768,
  parameter int LOOKAHEAD_SIZE = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire lz77_pkg::in_item_t q_item,
  output logic                    q_pop,
  output logic                    tok_valid,
  output lz77_pkg::token_t        tok,
  input  wire logic               tok_ready
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam int FW = $clog2(WINDOW_SIZE + 1);
  localparam int CW = $clog2(LOOKAHEAD_SIZE + 1);
  localparam int LW = $clog2(LOOKAHEAD_SIZE);

  lz77_pkg::eng_state_t state, state_next;

  logic [7:0]    hist [WINDOW_SIZE];
  logic [7:0]    hist_q;
  logic [AW-1:0] hist_addr;
  logic          hist_we;

  logic [7:0]    la [LOOKAHEAD_SIZE];
  logic [CW-1:0] count;
  logic          flush;
  logic [FW-1:0] fill;
  logic [AW-1:0] head;

  logic [FW-1:0] iss_p;
  logic [AW-1:0] raddr;
  logic          pv;
  logic [FW-1:0] pp;
  logic [LOOKAHEAD_SIZE-1:0] alive;
  logic [LOOKAHEAD_SIZE-1:0] alive_next;
  logic [LW-1:0] best_len;
  logic [FW-1:0] best_off;
  logic [LW-1:0] k;
  logic [7:0]    literal;

  logic [FW-1:0] start;
  logic          hit;
  logic [LW-1:0] hit_len;
  logic [FW-1:0] hit_off;
  logic          go_token;
  logic          emit_go;

  always_comb begin
    if (FW'(head) >= fill) start = FW'(head) - fill;
    else                   start = FW'(head) + FW'(WINDOW_SIZE) - fill;
  end

  // parallel lane compare of the history byte against each lookahead byte but the last
  always_comb begin
    alive_next = '0;
    hit        = 1'b0;
    hit_len    = '0;
    hit_off    = '0;
    for (int j = 0; j < LOOKAHEAD_SIZE - 1; j++) begin
      if ((CW'(j + 1) < count) && ((j == 0) || alive[j]) && (hist_q == la[j])) begin
        alive_next[j+1] = 1'b1;
        hit     = 1'b1;
        hit_len = LW'(j + 1);
        hit_off = fill - pp + FW'(j);
      end
    end
  end

  assign go_token = (count == CW'(LOOKAHEAD_SIZE)) || (flush && count != '0);
  assign emit_go  = !tok_valid || tok_ready;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      lz77_pkg::ST_IDLE: begin
        if (go_token) state_next = lz77_pkg::ST_SCAN;
        else if (q_valid) q_pop = 1'b1;
      end
      lz77_pkg::ST_SCAN: begin
        if (iss_p == fill && !pv) state_next = lz77_pkg::ST_CONSUME;
      end
      lz77_pkg::ST_CONSUME: begin
        if (k == best_len) state_next = lz77_pkg::ST_EMIT;
      end
      lz77_pkg::ST_EMIT: begin
        if (emit_go) state_next = lz77_pkg::ST_IDLE;
      end
      default: state_next = lz77_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lz77_pkg::ST_IDLE;
    else     state <= state_next;
  end

  assign hist_we   = (state == lz77_pkg::ST_CONSUME);
  assign hist_addr = hist_we ? head : raddr;

  always_ff @(posedge clk) begin
    if (hist_we) hist[hist_addr] <= la[0];
    hist_q <= hist[hist_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      flush     <= 1'b0;
      fill      <= '0;
      head      <= '0;
      pv        <= 1'b0;
      tok_valid <= 1'b0;
    end else begin
      if (tok_valid && tok_ready && state != lz77_pkg::ST_EMIT) tok_valid <= 1'b0;
      unique case (state)
        lz77_pkg::ST_IDLE: begin
          iss_p    <= '0;
          raddr    <= AW'(start);
          alive    <= '0;
          best_len <= '0;
          best_off <= '0;
          k        <= '0;
          pv       <= 1'b0;
          if (!go_token && q_valid) begin
            for (int j = 0; j < LOOKAHEAD_SIZE; j++) begin
              if (CW'(j) == count) la[j] <= q_item.data;
            end
            count <= count + 1'b1;
            if (q_item.eos) flush <= 1'b1;
          end
        end
        lz77_pkg::ST_SCAN: begin
          pv <= (iss_p != fill);
          pp <= iss_p;
          if (iss_p != fill) begin
            iss_p <= iss_p + 1'b1;
            raddr <= (raddr == AW'(WINDOW_SIZE - 1)) ? '0 : raddr + 1'b1;
          end
          if (pv) begin
            alive <= alive_next;
            if (hit && hit_len > best_len) begin
              best_len <= hit_len;
              best_off <= hit_off;
            end
          end
        end
        lz77_pkg::ST_CONSUME: begin
          head <= (head == AW'(WINDOW_SIZE - 1)) ? '0 : head + 1'b1;
          if (fill != FW'(WINDOW_SIZE)) fill <= fill + 1'b1;
          for (int j = 0; j < LOOKAHEAD_SIZE - 1; j++) la[j] <= la[j+1];
          count <= count - 1'b1;
          k     <= k + 1'b1;
          if (k == best_len) literal <= la[0];
        end
        lz77_pkg::ST_EMIT: begin
          if (emit_go) begin
            tok_valid   <= 1'b1;
            tok.offset  <= lz77_pkg::OFFSET_W'(best_off);
            tok.length  <= lz77_pkg::LENGTH_W'(best_len);
            tok.literal <= literal;
            tok.last    <= flush && (count == '0);
            if (flush && count == '0) begin
              flush <= 1'b0;
              fill  <= '0;
              head  <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW_SIZE)) else $error("history fill beyond window");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    (state == lz77_pkg::ST_SCAN) |-> (CW'(best_len) < count))
    else $error("match length reaches past lookahead");

  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    (state == lz77_pkg::ST_EMIT && emit_go && flush && count == '0) |=> (fill == '0 && !flush))
    else $error("window not cleared at stream end");

endmodule

`default_nettype wire

// File: src/lz77_token_encoder_top.sv
// lz77 token encoder top level: input queue feeding the match engine
// depends on lz77_pkg, lz77_in_queue, lz77_match_engine
`default_nettype none

// Bytes go into a short queue and then into a lookahead of LOOKAHEAD_SIZE
// bytes; a token is made each time it is full and, after a byte with tlast,
// until it is empty. For each token the engine scans the fill bytes of
// history (one history byte per cycle through the single port history
// memory, all lookahead lanes compared at once), moves the length + 1
// consumed bytes into the history and then loads the output register once
// it is free; bytes enter the lookahead only between tokens. The history
// memory needs no clearing pass after reset.
module lz77_token_encoder_top #(
  parameter int WINDOW_SIZE    = 32768,
  parameter int LOOKAHEAD_SIZE = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // data_byte
  input  wire logic        s_tlast,  // end_of_stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // match_offset, match_length, literal_byte, zero pad
  output logic             m_tlast   // last_token
);

  logic               q_valid;
  logic               q_pop;
  lz77_pkg::in_item_t q_item;
  lz77_pkg::token_t   tok;

  lz77_in_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lz77_match_engine #(
    .WINDOW_SIZE    (WINDOW_SIZE),
    .LOOKAHEAD_SIZE (LOOKAHEAD_SIZE)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .tok_valid (m_tvalid),
    .tok       (tok),
    .tok_ready (m_tready)
  );

  assign m_tdata = {3'b000, tok.literal, tok.length, tok.offset};
  assign m_tlast = tok.last;

endmodule

`default_nettype wire
